FILE: hdl/ttte_pkg.sv
// Shared types, codes and constants of the timer table tick engine.
package ttte_pkg;

  localparam int unsigned TIMERS_PER_TABLE_DEF = 16;
  localparam int unsigned TASK_LIMIT_DEF       = 32;
  localparam int unsigned QUEUE_DEPTH          = 2;
  localparam logic [31:0] MAX_DURATION_RST     = 32'd65535;

  localparam int unsigned S_TDATA_W = 56;
  localparam int unsigned M_TDATA_W = 40;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_TICK  = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_TASK       = 3'd1,
    ERR_DURATION   = 3'd2,
    ERR_KIND       = 3'd3,
    ERR_ID         = 3'd4,
    ERR_RESOLUTION = 3'd5
  } err_code_e;

  typedef enum logic [1:0] {
    RK_ACCEPT  = 2'd0,
    RK_REJECT  = 2'd1,
    RK_TIMEOUT = 2'd2,
    RK_DONE    = 2'd3
  } result_kind_e;

  typedef enum logic [1:0] {
    ST_DEACT   = 2'd0,
    ST_STARTED = 2'd1,
    ST_ACTIVE  = 2'd2,
    ST_STOPPED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_REJECT = 2'd0,
    CMD_START  = 2'd1,
    CMD_STOP   = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_op_e;

  typedef enum logic [1:0] {
    BS_IDLE    = 2'd0,
    BS_STOP_RD = 2'd1,
    BS_WALK    = 2'd2,
    BS_DONE    = 2'd3
  } back_state_e;

  typedef struct packed {
    cmd_op_e     op;
    err_code_e   err;
    logic        res;
    logic [7:0]  task_id;
    logic [7:0]  slot_id;
    logic [31:0] duration;
    logic        periodic;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  owner;
    logic [31:0] duration;
    logic        periodic;
    logic [31:0] remaining;
  } entry_t;

  typedef struct packed {
    result_kind_e kind;
    err_code_e    error_code;
    logic         owner_matched;
    logic [7:0]   owner_task;
    logic [7:0]   expired_id;
    logic         expired_resolution;
    logic [15:0]  error_total;
    logic         last;
  } result_t;

endpackage

FILE: hdl/ttte_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ttte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/ttte_front.sv
// Front end: holds the duration limit, checks requests and turns them into commands.
module ttte_front
  import ttte_pkg::*;
#(
  parameter int unsigned TIMERS_PER_TABLE = TIMERS_PER_TABLE_DEF,
  parameter int unsigned TASK_LIMIT       = TASK_LIMIT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 s_valid_i,
  input  logic [1:0]           s_opcode_i,
  input  logic [S_TDATA_W-1:0] s_data_i,
  output logic                 s_ready_o,
  input  logic                 q_ready_i,
  output logic                 push_o,
  output cmd_t                 cmd_o
);

  localparam logic [7:0] TASK_LIM  = 8'(TASK_LIMIT);
  localparam logic [7:0] TIMER_LIM = 8'(TIMERS_PER_TABLE);

  logic [31:0] max_dur_q;
  logic [1:0]  resolution;
  logic [7:0]  task_id;
  logic [7:0]  slot_id;
  logic [31:0] duration;
  logic [1:0]  timer_kind;
  logic        task_ok;
  logic        id_ok;
  logic        dur_ok;
  logic        known_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dur_q <= MAX_DURATION_RST;
    end else if (cfg_we_i) begin
      max_dur_q <= cfg_wdata_i;
    end
  end

  assign resolution = s_data_i[1:0];
  assign task_id    = s_data_i[9:2];
  assign slot_id    = s_data_i[17:10];
  assign duration   = s_data_i[49:18];
  assign timer_kind = s_data_i[51:50];

  assign task_ok = (task_id != 8'd0) && (task_id < TASK_LIM);
  assign id_ok   = (slot_id != 8'd0) && (slot_id < TIMER_LIM);
  assign dur_ok  = (duration != 32'd0) && (duration <= max_dur_q);

  always_comb begin
    cmd_o.op       = CMD_REJECT;
    cmd_o.err      = ERR_NONE;
    cmd_o.res      = resolution[0];
    cmd_o.task_id  = task_id;
    cmd_o.slot_id  = slot_id;
    cmd_o.duration = duration;
    cmd_o.periodic = timer_kind[0];
    known_op       = 1'b1;
    unique case (s_opcode_i)
      OP_START: begin
        if (!task_ok) begin
          cmd_o.err = ERR_TASK;
        end else if (!dur_ok) begin
          cmd_o.err = ERR_DURATION;
        end else if (timer_kind[1]) begin
          cmd_o.err = ERR_KIND;
        end else if (resolution[1]) begin
          cmd_o.err = ERR_RESOLUTION;
        end else if (!id_ok) begin
          cmd_o.err = ERR_ID;
        end else begin
          cmd_o.op = CMD_START;
        end
      end
      OP_STOP: begin
        if (!task_ok) begin
          cmd_o.err = ERR_TASK;
        end else if (resolution[1]) begin
          cmd_o.err = ERR_RESOLUTION;
        end else if (!id_ok) begin
          cmd_o.err = ERR_ID;
        end else begin
          cmd_o.op = CMD_STOP;
        end
      end
      OP_TICK: begin
        if (resolution[1]) begin
          cmd_o.err = ERR_RESOLUTION;
        end else begin
          cmd_o.op = CMD_TICK;
        end
      end
      default: begin
        known_op = 1'b0;
      end
    endcase
  end

  assign s_ready_o = q_ready_i;
  assign push_o    = s_valid_i && q_ready_i && known_op;

endmodule

FILE: hdl/ttte_fifo.sv
// Short command queue between the front end and the back end.
module ttte_fifo
  import ttte_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic ready_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t cmd_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             buf_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  assign ready_o = count_q != CNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign cmd_o   = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

FILE: hdl/ttte_back.sv
// Back end: executes commands against the timer tables and drives the result register.
module ttte_back
  import ttte_pkg::*;
#(
  parameter int unsigned TIMERS_PER_TABLE = TIMERS_PER_TABLE_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  input  cmd_t    cmd_i,
  output logic    pop_o,
  output logic    result_valid_o,
  input  logic    result_ready_i,
  output result_t result_o
);

  localparam int unsigned SLOTS  = 2 * TIMERS_PER_TABLE;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned IDX_W  = $clog2(TIMERS_PER_TABLE);

  back_state_e       state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [15:0]       cnt_q, cnt_d, cnt_inc;
  logic              out_valid_q;
  result_t           out_q, out_d;
  logic              out_load;
  logic              out_free;
  status_e           status_q [SLOTS];
  logic [SLOTS-1:0]  written_q;

  logic              st_we;
  logic [SLOT_W-1:0] st_addr;
  status_e           st_wdata;
  logic              wr_set;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  entry_t            rd_entry;

  logic [SLOT_W-1:0] cmd_slot;
  logic [SLOT_W-1:0] base_slot;
  logic [SLOT_W-1:0] walk_slot;
  status_e           cur_status;
  logic              emit;
  logic              upd_ram;
  logic              upd_st;
  status_e           upd_st_val;
  entry_t            upd_entry;

  ttte_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rd_entry)
  );

  assign base_slot  = cmd_i.res ? SLOT_W'(TIMERS_PER_TABLE) : '0;
  assign cmd_slot   = base_slot + cmd_i.slot_id[SLOT_W-1:0];
  assign walk_slot  = base_slot + SLOT_W'(idx_q);
  assign cur_status = status_q[walk_slot];
  assign out_free   = !out_valid_q || result_ready_i;
  assign cnt_inc    = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;

  // Work out what the current table entry needs during a tick walk.
  always_comb begin
    emit       = 1'b0;
    upd_ram    = 1'b0;
    upd_st     = 1'b0;
    upd_st_val = ST_ACTIVE;
    upd_entry  = rd_entry;
    case (cur_status)
      ST_ACTIVE: begin
        upd_ram = 1'b1;
        if (rd_entry.remaining != 32'd0) begin
          upd_entry.remaining = rd_entry.remaining - 32'd1;
        end else begin
          emit = 1'b1;
          if (rd_entry.periodic) begin
            upd_entry.remaining = rd_entry.duration - 32'd1;
          end else begin
            upd_entry.remaining = 32'd0;
            upd_st              = 1'b1;
            upd_st_val          = ST_STOPPED;
          end
        end
      end
      ST_STARTED: begin
        upd_ram             = 1'b1;
        upd_st              = 1'b1;
        upd_st_val          = ST_ACTIVE;
        upd_entry.remaining = rd_entry.duration;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    pop_o     = 1'b0;
    out_load  = 1'b0;
    out_d     = '0;
    out_d.error_total = cnt_q;
    st_we     = 1'b0;
    st_addr   = cmd_slot;
    st_wdata  = ST_DEACT;
    wr_set    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cmd_slot;
    ram_wdata = upd_entry;
    ram_re    = 1'b0;
    ram_raddr = cmd_slot;
    unique case (state_q)
      BS_IDLE: begin
        if (q_valid_i) begin
          unique case (cmd_i.op)
            CMD_REJECT: begin
              if (out_free) begin
                out_load          = 1'b1;
                out_d.kind        = RK_REJECT;
                out_d.error_code  = cmd_i.err;
                out_d.error_total = cnt_inc;
                out_d.last        = 1'b1;
                cnt_d             = cnt_inc;
                pop_o             = 1'b1;
              end
            end
            CMD_START: begin
              if (out_free) begin
                ram_we              = 1'b1;
                ram_wdata.owner     = cmd_i.task_id;
                ram_wdata.duration  = cmd_i.duration;
                ram_wdata.periodic  = cmd_i.periodic;
                ram_wdata.remaining = '0;
                st_we               = 1'b1;
                st_wdata            = ST_STARTED;
                wr_set              = 1'b1;
                out_load            = 1'b1;
                out_d.kind          = RK_ACCEPT;
                out_d.last          = 1'b1;
                pop_o               = 1'b1;
              end
            end
            CMD_STOP: begin
              ram_re  = 1'b1;
              state_d = BS_STOP_RD;
            end
            CMD_TICK: begin
              ram_re    = 1'b1;
              ram_raddr = base_slot;
              idx_d     = '0;
              state_d   = BS_WALK;
            end
            default: begin
            end
          endcase
        end
      end
      BS_STOP_RD: begin
        if (out_free) begin
          st_we               = 1'b1;
          out_d.owner_matched = written_q[cmd_slot] && (rd_entry.owner == cmd_i.task_id);
          st_wdata            = out_d.owner_matched ? ST_STOPPED : ST_DEACT;
          out_load            = 1'b1;
          out_d.kind          = RK_ACCEPT;
          out_d.last          = 1'b1;
          pop_o               = 1'b1;
          state_d             = BS_IDLE;
        end
      end
      BS_WALK: begin
        if (!emit || out_free) begin
          ram_we    = upd_ram;
          ram_waddr = walk_slot;
          st_we     = upd_st;
          st_addr   = walk_slot;
          st_wdata  = upd_st_val;
          if (emit) begin
            out_load                 = 1'b1;
            out_d.kind               = RK_TIMEOUT;
            out_d.owner_task         = rd_entry.owner;
            out_d.expired_id         = 8'(idx_q);
            out_d.expired_resolution = cmd_i.res;
          end
          if (idx_q == IDX_W'(TIMERS_PER_TABLE - 1)) begin
            state_d = BS_DONE;
          end else begin
            idx_d     = idx_q + IDX_W'(1);
            ram_re    = 1'b1;
            ram_raddr = walk_slot + SLOT_W'(1);
          end
        end
      end
      BS_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_d.kind = RK_DONE;
          out_d.last = 1'b1;
          pop_o      = 1'b1;
          state_d    = BS_IDLE;
        end
      end
      default: begin
        state_d = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      written_q   <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        status_q[i] <= ST_DEACT;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (st_we) begin
        status_q[st_addr] <= st_wdata;
      end
      if (wr_set) begin
        written_q[cmd_slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

`ifndef NO_ASSERTIONS
  a_pop_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> out_load)
    else $error("Command retired without a result.");

  a_ram_no_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write hit the same slot.");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (cnt_q >= $past(cnt_q)))
    else $error("Error counter decreased.");

  a_walk_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != BS_IDLE) |-> q_valid_i)
    else $error("Command queue emptied while a command was in progress.");
`endif

endmodule

FILE: hdl/timer_table_tick_engine_unit.sv
// Top level: request and tick stream in, timeout and status stream out.
// A start or reject result is registered after the command queue; a stop first
// reads the entry RAM, and a tick walks one table, one entry per cycle unless a
// timeout stalls. The rate is set by the walk through the single-read entry RAM.
// Reset clears all entry states to deactivated, the error counter to zero and
// max_duration to 65535; the entry RAM itself is not cleared and needs no pass.
module timer_table_tick_engine_unit
  import ttte_pkg::*;
#(
  parameter int unsigned TIMERS_PER_TABLE = TIMERS_PER_TABLE_DEF,
  parameter int unsigned TASK_LIMIT       = TASK_LIMIT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // opcode
  input  logic [1:0]           s_axis_tuser,
  // resolution, task_id, slot_id, duration, timer_kind, zero padding
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // result_kind
  output logic [1:0]           m_axis_tuser,
  // error_code, owner_matched, owner_task, expired_id, expired_resolution,
  // error_total, zero padding
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic                 m_axis_tlast
);

  logic    push;
  logic    q_ready;
  logic    q_valid;
  logic    pop;
  cmd_t    push_cmd;
  cmd_t    head_cmd;
  result_t result;

  ttte_front #(
    .TIMERS_PER_TABLE(TIMERS_PER_TABLE),
    .TASK_LIMIT      (TASK_LIMIT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_valid_i  (s_axis_tvalid),
    .s_opcode_i (s_axis_tuser),
    .s_data_i   (s_axis_tdata),
    .s_ready_o  (s_axis_tready),
    .q_ready_i  (q_ready),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  ttte_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .ready_o(q_ready),
    .valid_o(q_valid),
    .pop_i  (pop),
    .cmd_o  (head_cmd)
  );

  ttte_back #(
    .TIMERS_PER_TABLE(TIMERS_PER_TABLE)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .result_valid_o(m_axis_tvalid),
    .result_ready_i(m_axis_tready),
    .result_o      (result)
  );

  assign m_axis_tuser = result.kind;
  assign m_axis_tlast = result.last;
  assign m_axis_tdata = {3'b000,
                         result.error_total,
                         result.expired_resolution,
                         result.expired_id,
                         result.owner_task,
                         result.owner_matched,
                         result.error_code};

endmodule

FILE: test/tb_timer_table_tick_engine_unit.sv
// Self-checking testbench for the timer table tick engine: random and directed stream traffic.
`timescale 1ns / 1ps

module tb_timer_table_tick_engine_unit;
  import ttte_pkg::*;

  localparam int TIMERS = TIMERS_PER_TABLE_DEF;
  localparam int TASK_LIM = TASK_LIMIT_DEF;
  localparam int SLOT_COUNT = 2 * TIMERS;
  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam logic [1:0] KIND_ONE_SHOT = 2'd0;
  localparam logic [1:0] KIND_PERIODIC = 2'd1;
  localparam logic [1:0] RES_SECOND = 2'd0;
  localparam logic [1:0] RES_TEN_MS = 2'd1;
  localparam int SETTLE_CYCLES = 3 * TIMERS;

  typedef struct {
    logic [1:0]  opcode;
    logic [1:0]  res;
    logic [7:0]  task_id;
    logic [7:0]  slot_id;
    logic [31:0] duration;
    logic [1:0]  kind;
  } timer_req_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [31:0]          cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [1:0]           s_axis_tuser = '0;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [1:0]           m_axis_tuser;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  timer_table_tick_engine_unit #(
    .TIMERS_PER_TABLE(TIMERS),
    .TASK_LIMIT(TASK_LIM)
  ) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  timer_req_t  req_queue[$];
  result_t     timer_results_due[$];
  int          sender_idle_pct = 0;
  int          receiver_idle_pct = 0;
  int          mismatch_count = 0;

  // Predicted block state.
  logic [31:0] max_duration_q = MAX_DURATION_RST;
  status_e     slot_status[SLOT_COUNT];
  logic [7:0]  slot_owner[SLOT_COUNT];
  logic [7:0]  slot_stored_id[SLOT_COUNT];
  logic [31:0] slot_duration[SLOT_COUNT];
  logic        slot_periodic[SLOT_COUNT];
  logic [31:0] slot_remaining[SLOT_COUNT];
  logic [15:0] reject_total;

  // Stimulus-side record of which slots have been armed and by whom.
  bit          gen_written[SLOT_COUNT];
  logic [7:0]  gen_owner[SLOT_COUNT];

  timer_req_t  s_in_flight;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("tb_timer_table_tick_engine_unit NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic void add_result(input result_kind_e k, input err_code_e e, input logic m,
                                     input logic [7:0] owner, input logic [7:0] id,
                                     input logic rb, input logic l);
    result_t r;
    r.kind = k;
    r.error_code = e;
    r.owner_matched = m;
    r.owner_task = owner;
    r.expired_id = id;
    r.expired_resolution = rb;
    r.error_total = reject_total;
    r.last = l;
    timer_results_due.push_back(r);
  endfunction

  function automatic void reject_request(input err_code_e e);
    if (reject_total != 16'hFFFF) begin
      reject_total++;
    end
    add_result(RK_REJECT, e, 1'b0, 8'd0, 8'd0, 1'b0, 1'b1);
  endfunction

  function automatic void compute_timer_results(input timer_req_t r);
    bit task_ok;
    bit id_ok;
    bit match;
    int s;
    task_ok = r.task_id >= 1 && r.task_id < TASK_LIM;
    id_ok = r.slot_id >= 1 && r.slot_id < TIMERS;
    s = id_ok ? int'(r.res[0]) * TIMERS + int'(r.slot_id) : 0;
    case (r.opcode)
      OP_START: begin
        if (!task_ok) reject_request(ERR_TASK);
        else if (r.duration == 0 || r.duration > max_duration_q) reject_request(ERR_DURATION);
        else if (r.kind > KIND_PERIODIC) reject_request(ERR_KIND);
        else if (r.res > RES_TEN_MS) reject_request(ERR_RESOLUTION);
        else if (!id_ok) reject_request(ERR_ID);
        else begin
          slot_owner[s] = r.task_id;
          slot_stored_id[s] = r.slot_id;
          slot_duration[s] = r.duration;
          slot_periodic[s] = r.kind[0];
          slot_status[s] = ST_STARTED;
          add_result(RK_ACCEPT, ERR_NONE, 1'b0, 8'd0, 8'd0, 1'b0, 1'b1);
        end
      end
      OP_STOP: begin
        if (!task_ok) reject_request(ERR_TASK);
        else if (r.res > RES_TEN_MS) reject_request(ERR_RESOLUTION);
        else if (!id_ok) reject_request(ERR_ID);
        else begin
          match = slot_owner[s] == r.task_id && slot_stored_id[s] == r.slot_id;
          slot_status[s] = match ? ST_STOPPED : ST_DEACT;
          add_result(RK_ACCEPT, ERR_NONE, match, 8'd0, 8'd0, 1'b0, 1'b1);
        end
      end
      OP_TICK: begin
        if (r.res > RES_TEN_MS) reject_request(ERR_RESOLUTION);
        else begin
          for (int i = 0; i < TIMERS; i++) begin
            s = int'(r.res[0]) * TIMERS + i;
            if (slot_status[s] == ST_ACTIVE) begin
              if (slot_remaining[s] >= 1) begin
                slot_remaining[s]--;
              end else begin
                if (slot_periodic[s]) begin
                  slot_remaining[s] = slot_duration[s] - 32'd1;
                end else begin
                  slot_status[s] = ST_STOPPED;
                  slot_remaining[s] = '0;
                end
                add_result(RK_TIMEOUT, ERR_NONE, 1'b0, slot_owner[s], slot_stored_id[s],
                           r.res[0], 1'b0);
              end
            end else if (slot_status[s] == ST_STARTED) begin
              slot_remaining[s] = slot_duration[s];
              slot_status[s] = ST_ACTIVE;
            end
          end
          add_result(RK_DONE, ERR_NONE, 1'b0, 8'd0, 8'd0, 1'b0, 1'b1);
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic queue_request(input timer_req_t r);
    bit task_ok;
    bit id_ok;
    int s;
    task_ok = r.task_id >= 1 && r.task_id < TASK_LIM;
    id_ok = r.slot_id >= 1 && r.slot_id < TIMERS;
    s = id_ok ? int'(r.res[0]) * TIMERS + int'(r.slot_id) : 0;
    if (r.opcode == OP_START && task_ok && r.duration != 0 && r.duration <= max_duration_q &&
        r.kind <= KIND_PERIODIC && r.res <= RES_TEN_MS && id_ok) begin
      gen_written[s] = 1'b1;
      gen_owner[s] = r.task_id;
    end
    req_queue.push_back(r);
  endtask

  task automatic queue_req(input logic [1:0] op, input logic [1:0] res, input logic [7:0] tsk,
                           input logic [7:0] tid, input logic [31:0] dur,
                           input logic [1:0] kind);
    timer_req_t r;
    r.opcode = op;
    r.res = res;
    r.task_id = tsk;
    r.slot_id = tid;
    r.duration = dur;
    r.kind = kind;
    queue_request(r);
  endtask

  task automatic queue_random(input int count);
    timer_req_t r;
    int pick;
    int armed[$];
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      r.opcode = OP_START;
      r.res = 2'($urandom_range(1, 0));
      r.task_id = 8'($urandom_range(TASK_LIM - 1, 1));
      r.slot_id = 8'($urandom_range(TIMERS - 1, 1));
      r.kind = 2'($urandom_range(1, 0));
      pick = $urandom_range(9);
      if (pick < 7) begin
        r.duration = $urandom_range(4, 1);
        if (r.duration > max_duration_q) r.duration = max_duration_q;
      end else if (pick < 9) begin
        r.duration = max_duration_q;
      end else begin
        r.duration = ($urandom % max_duration_q) + 32'd1;
      end
      pick = $urandom_range(99);
      if (pick < 35) begin
        r.opcode = OP_TICK;
      end else if (pick < 55) begin
        armed.delete();
        for (int s = 0; s < SLOT_COUNT; s++) begin
          if (gen_written[s]) armed.push_back(s);
        end
        if (armed.size() != 0) begin
          pick = armed[$urandom_range(armed.size() - 1)];
          r.opcode = OP_STOP;
          r.res = 2'(pick / TIMERS);
          r.slot_id = 8'(pick % TIMERS);
          if ($urandom_range(9) < 7) r.task_id = gen_owner[pick];
        end
      end else if (pick >= 80) begin
        r.opcode = 2'($urandom_range(3, 0));
        r.res = 2'($urandom_range(3, 0));
        r.task_id = 8'($urandom);
        r.slot_id = 8'($urandom);
        r.duration = $urandom;
        r.kind = 2'($urandom_range(3, 0));
      end
      queue_request(r);
    end
  endtask

  task automatic write_max_duration(input logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    max_duration_q = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk_i);
    while (req_queue.size() != 0 || s_axis_tvalid || timer_results_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    timer_req_t nxt;
    if (s_axis_tvalid && s_axis_tready) begin
      compute_timer_results(s_in_flight);
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (req_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        nxt = req_queue.pop_front();
        s_in_flight = nxt;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= nxt.opcode;
        s_axis_tdata <= {4'b0, nxt.kind, nxt.duration, nxt.slot_id, nxt.task_id, nxt.res};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      m_axis_tready <= $urandom_range(99) >= receiver_idle_pct;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (timer_results_due.size() == 0) begin
        report_mismatch("result transaction with no result pending");
      end else begin
        want = timer_results_due.pop_front();
        check_field("result_kind", 32'(m_axis_tuser), 32'(want.kind));
        check_field("error_code", 32'(m_axis_tdata[2:0]), 32'(want.error_code));
        check_field("owner_matched", 32'(m_axis_tdata[3]), 32'(want.owner_matched));
        check_field("owner_task", 32'(m_axis_tdata[11:4]), 32'(want.owner_task));
        check_field("expired_id", 32'(m_axis_tdata[19:12]), 32'(want.expired_id));
        check_field("expired_resolution", 32'(m_axis_tdata[20]),
                    32'(want.expired_resolution));
        check_field("error_total", 32'(m_axis_tdata[36:21]), 32'(want.error_total));
        check_field("last", 32'(m_axis_tlast), 32'(want.last));
      end
    end
  end

  initial begin
    for (int s = 0; s < SLOT_COUNT; s++) begin
      slot_status[s] = ST_DEACT;
      slot_owner[s] = '0;
      slot_stored_id[s] = '0;
      slot_duration[s] = '0;
      slot_periodic[s] = 1'b0;
      slot_remaining[s] = '0;
      gen_written[s] = 1'b0;
      gen_owner[s] = '0;
    end
    reject_total = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    sender_idle_pct = 10;
    receiver_idle_pct = 58;
    queue_req(OP_TICK, RES_SECOND, 8'd0, 8'd0, 32'd0, KIND_ONE_SHOT);
    queue_req(OP_START, RES_SECOND, 8'd1, 8'd1, 32'd1, KIND_ONE_SHOT);
    queue_req(OP_START, RES_TEN_MS, 8'd31, 8'd15, 32'd65535, KIND_PERIODIC);
    queue_req(OP_START, RES_SECOND, 8'd0, 8'd2, 32'd5, KIND_ONE_SHOT);
    queue_req(OP_START, RES_SECOND, 8'd32, 8'd2, 32'd5, KIND_ONE_SHOT);
    queue_req(OP_START, 2'd3, 8'd255, 8'd255, 32'd0, 2'd3);
    queue_req(OP_START, RES_SECOND, 8'd5, 8'd2, 32'd0, KIND_ONE_SHOT);
    queue_req(OP_START, RES_SECOND, 8'd5, 8'd2, 32'd65536, KIND_ONE_SHOT);
    queue_req(OP_START, 2'd3, 8'd5, 8'd2, 32'hFFFF_FFFF, 2'd3);
    queue_req(OP_START, RES_SECOND, 8'd5, 8'd2, 32'd3, 2'd2);
    queue_req(OP_START, 2'd2, 8'd5, 8'd0, 32'd3, KIND_PERIODIC);
    queue_req(OP_START, RES_TEN_MS, 8'd5, 8'd0, 32'd2, KIND_PERIODIC);
    queue_req(OP_START, RES_TEN_MS, 8'd5, 8'd16, 32'd2, KIND_PERIODIC);
    queue_req(OP_START, RES_TEN_MS, 8'd5, 8'd255, 32'd2, KIND_PERIODIC);
    queue_req(OP_START, RES_SECOND, 8'd7, 8'd2, 32'd2, KIND_PERIODIC);
    queue_req(OP_STOP, RES_SECOND, 8'd0, 8'd1, 32'd0, KIND_ONE_SHOT);
    queue_req(OP_STOP, 2'd3, 8'd3, 8'd1, 32'd0, KIND_ONE_SHOT);
    queue_req(OP_STOP, RES_SECOND, 8'd3, 8'd0, 32'd0, KIND_ONE_SHOT);
    queue_req(OP_STOP, RES_TEN_MS, 8'd9, 8'd15, 32'd0, KIND_ONE_SHOT);
    queue_req(OP_START, RES_TEN_MS, 8'd4, 8'd3, 32'd2, KIND_ONE_SHOT);
    queue_req(OP_STOP, RES_TEN_MS, 8'd4, 8'd3, 32'd0, KIND_ONE_SHOT);
    for (int n = 0; n < 4; n++) begin
      queue_req(OP_TICK, RES_SECOND, 8'd0, 8'd0, 32'd0, KIND_ONE_SHOT);
    end
    queue_req(OP_TICK, RES_TEN_MS, 8'd0, 8'd0, 32'd0, KIND_ONE_SHOT);
    queue_req(OP_TICK, 2'd2, 8'd0, 8'd0, 32'd0, KIND_ONE_SHOT);
    queue_req(OP_TICK, 2'd3, 8'd0, 8'd0, 32'd0, KIND_ONE_SHOT);
    queue_req(OP_IGNORED, 2'd3, 8'd255, 8'd255, 32'hFFFF_FFFF, 2'd3);
    settle();

    write_max_duration(32'd1);
    queue_random(25);
    settle();

    sender_idle_pct = 58;
    receiver_idle_pct = 10;
    write_max_duration(32'hFFFF_FFFF);
    queue_random(25);
    settle();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    write_max_duration(32'd20);
    queue_random(20);
    settle();

    if (mismatch_count == 0) begin
      $display("tb_timer_table_tick_engine_unit OK");
    end else begin
      $display("tb_timer_table_tick_engine_unit NOT OK");
    end
    $finish;
  end

endmodule
